### sv/shad_pkg.sv
// Shared constants and functions of the sine/cosine Hall angle decoder.
`timescale 1ns / 1ps
package shad_pkg;

    // Defaults of the module parameters.
    localparam int ADC_BITS_DEF   = 12;
    localparam int ANGLE_BITS_DEF = 16;

    // Fixed-point constants of the normalizer and the CORDIC.
    localparam int NORM_W       = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int ZW           = 32;
    // Rotator registers hold norm << 14 with CORDIC growth headroom.
    localparam int XYW          = 34;
    localparam int Q_ONE        = 16384;

    // Input action codes.
    localparam logic [1:0] ACT_RESTART = 2'd0;
    localparam logic [1:0] ACT_CAL     = 2'd1;
    localparam logic [1:0] ACT_MEASURE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SPAN    = 2'd1;
    localparam logic [1:0] ST_NOCAL   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_MIN_A  = 3'd0;
    localparam logic [2:0] REG_MAX_A  = 3'd1;
    localparam logic [2:0] REG_MIN_B  = 3'd2;
    localparam logic [2:0] REG_MAX_B  = 3'd3;
    localparam logic [2:0] REG_USE_PR = 3'd4;

    // Arctangent table in units of 2^-32 turn.
    function automatic logic [ZW-1:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [ZW-1:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### sv/shad_front.sv
// Front end: takes input transfers, keeps the calibration extremes and queues measure jobs.
`timescale 1ns / 1ps
module shad_front #(
    parameter int ADC_BITS = shad_pkg::ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_action,
    input  logic [ADC_BITS-1:0] i_sample_a,
    input  logic [ADC_BITS-1:0] i_sample_b,
    input  logic [ADC_BITS-1:0] i_pmin_a,
    input  logic [ADC_BITS-1:0] i_pmax_a,
    input  logic [ADC_BITS-1:0] i_pmin_b,
    input  logic [ADC_BITS-1:0] i_pmax_b,
    input  logic                i_use_preset,
    // Job queue towards the back end: {status, a, b, lo_a, hi_a, lo_b, hi_b}.
    output logic                o_job_valid,
    input  logic                i_job_ready,
    output logic [1:0]          o_job_status,
    output logic [ADC_BITS-1:0] o_job_sa,
    output logic [ADC_BITS-1:0] o_job_sb,
    output logic [ADC_BITS-1:0] o_job_lo_a,
    output logic [ADC_BITS-1:0] o_job_hi_a,
    output logic [ADC_BITS-1:0] o_job_lo_b,
    output logic [ADC_BITS-1:0] o_job_hi_b
);
    import shad_pkg::*;

    localparam int JW = 2 + 6 * ADC_BITS;

    logic [ADC_BITS-1:0] r_tmin_a, r_tmax_a, r_tmin_b, r_tmax_b;
    logic                r_tvalid;
    logic [JW-1:0]       r_q [2];
    logic                r_wp, r_rp;
    logic [1:0]          r_cnt;

    logic                acc, push, pop;
    logic [ADC_BITS-1:0] lo_a, hi_a, lo_b, hi_b;
    logic [1:0]          st;
    logic [JW-1:0]       job;

    assign o_ready = (r_cnt != 2'd2);
    assign acc     = i_valid && o_ready;
    assign push    = acc && (i_action == ACT_MEASURE);
    assign pop     = o_job_valid && i_job_ready;

    // Choose the extremes and classify the job.
    always_comb begin
        if (i_use_preset) begin
            lo_a = i_pmin_a; hi_a = i_pmax_a; lo_b = i_pmin_b; hi_b = i_pmax_b;
        end else begin
            lo_a = r_tmin_a; hi_a = r_tmax_a; lo_b = r_tmin_b; hi_b = r_tmax_b;
        end
        if (!i_use_preset && !r_tvalid) begin
            st = ST_NOCAL;
        end else if (hi_a <= lo_a || hi_b <= lo_b) begin
            st = ST_SPAN;
        end else begin
            st = ST_OK;
        end
        job = {st, i_sample_a, i_sample_b, lo_a, hi_a, lo_b, hi_b};
    end

    // Calibration tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
            r_tmin_a <= '0; r_tmax_a <= '0; r_tmin_b <= '0; r_tmax_b <= '0;
        end else if (acc && i_action == ACT_RESTART) begin
            r_tvalid <= 1'b0;
        end else if (acc && i_action == ACT_CAL) begin
            r_tvalid <= 1'b1;
            if (!r_tvalid) begin
                r_tmin_a <= i_sample_a; r_tmax_a <= i_sample_a;
                r_tmin_b <= i_sample_b; r_tmax_b <= i_sample_b;
            end else begin
                if (i_sample_a < r_tmin_a) r_tmin_a <= i_sample_a;
                if (i_sample_a > r_tmax_a) r_tmax_a <= i_sample_a;
                if (i_sample_b < r_tmin_b) r_tmin_b <= i_sample_b;
                if (i_sample_b > r_tmax_b) r_tmax_b <= i_sample_b;
            end
        end
    end

    // Two-entry job queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= job;
    end

    assign o_job_valid = (r_cnt != 2'd0);
    assign {o_job_status, o_job_sa, o_job_sb, o_job_lo_a, o_job_hi_a, o_job_lo_b,
            o_job_hi_b} = r_q[r_rp];

    // The queue never holds more than two jobs.
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("job queue overflow");
    // A full queue refuses input.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("ready while full");
    // A calibration transfer always leaves the tracker valid.
    a_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_action == ACT_CAL |=> r_tvalid) else $error("tracker not valid");

endmodule

### sv/shad_back.sv
// Back end: normalizes both channels by restoring division and runs the CORDIC.
`timescale 1ns / 1ps
module shad_back #(
    parameter int ADC_BITS   = shad_pkg::ADC_BITS_DEF,
    parameter int ANGLE_BITS = shad_pkg::ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    output logic                  o_job_ready,
    input  logic [1:0]            i_job_status,
    input  logic [ADC_BITS-1:0]   i_job_sa,
    input  logic [ADC_BITS-1:0]   i_job_sb,
    input  logic [ADC_BITS-1:0]   i_job_lo_a,
    input  logic [ADC_BITS-1:0]   i_job_hi_a,
    input  logic [ADC_BITS-1:0]   i_job_lo_b,
    input  logic [ADC_BITS-1:0]   i_job_hi_b,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ANGLE_BITS-1:0] o_angle,
    output logic [shad_pkg::NORM_W-1:0] o_norm_a,
    output logic [shad_pkg::NORM_W-1:0] o_norm_b,
    output logic [1:0]            o_status
);
    import shad_pkg::*;

    // Quotient of (d*65536 + span) / (2*span) needs at most 16 bits (d < span).
    localparam int QB = 16;
    localparam int NW = ADC_BITS + 17;
    localparam int DW = ADC_BITS + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIVA = 3'd1;
    localparam logic [2:0] S_DIVB = 3'd2;
    localparam logic [2:0] S_ROT  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [4:0]            r_cnt;
    logic [ADC_BITS-1:0]   r_sb, r_lo_b, r_hi_b;
    logic [NW-1:0]         r_rem;
    logic [DW-1:0]         r_den;
    logic [QB-1:0]         r_quo;
    logic [1:0]            r_sat;
    logic signed [NORM_W-1:0] r_na, r_nb;
    logic signed [XYW-1:0] r_x, r_y;
    logic [ZW-1:0]         r_z;
    logic                  r_zero;

    // Per-channel set-up of the divider: saturation flags, the dividend and the divisor.
    function automatic logic [NW+DW+1:0] div_setup(input logic [ADC_BITS-1:0] x,
            input logic [ADC_BITS-1:0] lo, input logic [ADC_BITS-1:0] hi);
        logic [ADC_BITS-1:0] sp, d;
        logic [NW-1:0] num;
        sp  = hi - lo;
        d   = x - lo;
        num = {1'b0, d, 16'd0} + NW'(sp);
        return {x <= lo, x >= hi, num, {sp, 1'b0}};
    endfunction

    logic [NW+DW+1:0]   su;
    logic [NW-1:0]      trial_hi;
    logic               fits;
    logic [QB-1:0]      q_next;
    logic signed [NORM_W-1:0] nres;
    logic signed [XYW-1:0] dx, dy;
    logic [ZW-1:0]      zr;

    always_comb begin
        su = (r_state == S_IDLE) ? div_setup(i_job_sa, i_job_lo_a, i_job_hi_a)
                                 : div_setup(r_sb, r_lo_b, r_hi_b);
        // Restoring step: compare the remainder with den << (QB-1-cnt).
        trial_hi = NW'({r_den, 15'd0} >> r_cnt);
        fits     = (r_rem >= trial_hi);
        q_next   = {r_quo[QB-2:0], fits};
        if (r_sat[1]) begin
            nres = -NORM_W'(Q_ONE);
        end else if (r_sat[0]) begin
            nres = NORM_W'(Q_ONE);
        end else begin
            nres = $signed(q_next) - NORM_W'(Q_ONE);
        end
        // Rotation cycle k applies CORDIC iteration k-1.
        dx = r_y >>> (r_cnt - 5'd1);
        dy = r_x >>> (r_cnt - 5'd1);
        zr = r_z + 32'h80000000 + (ZW'(1) << (31 - ANGLE_BITS));
    end

    assign o_job_ready = (r_state == S_IDLE) && (!o_valid || i_ready);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_job_valid && o_job_ready && i_job_status == ST_OK) n_state = S_DIVA;
            S_DIVA: if (r_cnt == 5'(QB - 1)) n_state = S_DIVB;
            S_DIVB: if (r_cnt == 5'(QB - 1)) n_state = S_ROT;
            S_ROT:  if (r_cnt == 5'(CORDIC_STEPS)) n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state != n_state) begin
                r_cnt <= '0;
            end else if (r_state != S_IDLE) begin
                r_cnt <= r_cnt + 5'd1;
            end
            if (r_state == S_OUT || (r_state == S_IDLE && i_job_valid && o_job_ready
                    && i_job_status != ST_OK)) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sb <= i_job_sb; r_lo_b <= i_job_lo_b; r_hi_b <= i_job_hi_b;
                {r_sat, r_rem, r_den} <= su;
                r_quo <= '0;
                if (i_job_valid && o_job_ready && i_job_status != ST_OK) begin
                    o_status <= i_job_status;
                    o_angle  <= '0; o_norm_a <= '0; o_norm_b <= '0;
                end
            end
            S_DIVA, S_DIVB: begin
                if (r_cnt == 5'(QB - 1) && r_state == S_DIVA) begin
                    // Channel A done: keep its result and set up channel B.
                    r_na <= nres;
                    {r_sat, r_rem, r_den} <= su;
                    r_quo <= '0;
                end else begin
                    if (fits) r_rem <= r_rem - trial_hi;
                    r_quo <= q_next;
                    if (r_cnt == 5'(QB - 1)) r_nb <= nres;
                end
            end
            S_ROT: begin
                if (r_cnt == 5'd0) begin
                    // Pre-rotation by half a turn when x is negative.
                    r_zero <= (r_na == 0) && (r_nb == 0);
                    if (r_nb < 0) begin
                        r_x <= -(XYW'(r_nb) <<< 14); r_y <= -(XYW'(r_na) <<< 14);
                        r_z <= 32'h80000000;
                    end else begin
                        r_x <= XYW'(r_nb) <<< 14; r_y <= XYW'(r_na) <<< 14;
                        r_z <= '0;
                    end
                    // First iteration is applied from the next cycle on.
                end else begin
                    if (r_y >= 0) begin
                        r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + atan_turn(r_cnt - 5'd1);
                    end else begin
                        r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - atan_turn(r_cnt - 5'd1);
                    end
                end
            end
            S_OUT: begin
                // Last iteration done together with output rounding would lengthen the path,
                // so the sequencer gives the output rounding a state of its own.
                o_status <= ST_OK;
                o_norm_a <= r_na; o_norm_b <= r_nb;
                o_angle  <= r_zero ? (ANGLE_BITS'(1) << (ANGLE_BITS - 1))
                                   : zr[ZW-1 -: ANGLE_BITS];
            end
            default: ;
        endcase
    end

    // A result is never overwritten while it waits.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result lost");
    // Jobs are taken only when idle.
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_ready |-> r_state == S_IDLE) else $error("job taken while busy");
    // The counter stays within the longest phase.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 5'(CORDIC_STEPS)) else $error("counter overrun");

endmodule

### sv/sincos_hall_angle_decoder.sv
// Top level of the sine/cosine Hall angle decoder.
`timescale 1ns / 1ps
// Usage:
// Input stream s_axis: tuser carries the action (restart, calibration sample,
// measure); tdata carries sample_a in the low ADC bits and sample_b above it.
// Restart and calibration transfers change the tracked extremes and give no
// result. Each measure transfer gives one result on m_axis: tdata holds
// angle_turn, norm_a and norm_b from the lowest bit up, tuser the status.
// Configuration is written over the cfg channel, index 0 to 4; the user must write
// it only while idle, as the block itself does not enforce this. A measure item
// passes through two 16-step restoring divisions (one per channel) and a CORDIC
// sequencer, and the back end takes a new measure only once it is idle again.
// A measure with a bad span or no calibration skips the divisions and the CORDIC
// and returns a zero result with its status. Calibration items stay in the front end;
// a two-entry job queue lets them and new measure jobs enter while the back end is busy.
// Reset clears the tracker, restores the preset registers and empties the
// queue. When the receiver stalls, the result register holds, the back end
// halts and the queue fills, after which s_axis_tready falls.
module sincos_hall_angle_decoder #(
    parameter int ADC_BITS   = shad_pkg::ADC_BITS_DEF,
    parameter int ANGLE_BITS = shad_pkg::ANGLE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata: sample_a, sample_b
    input  logic [((2*ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: action
    input  logic [1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata: angle_turn, norm_a, norm_b
    output logic [((ANGLE_BITS+32+7)/8)*8-1:0] m_axis_tdata,
    // tuser: status
    output logic [1:0] m_axis_tuser,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import shad_pkg::*;

    localparam int OTW = ((ANGLE_BITS + 32 + 7) / 8) * 8;

    logic [ADC_BITS-1:0] r_pmin_a, r_pmax_a, r_pmin_b, r_pmax_b;
    logic                r_use_preset;

    logic                jv, jr;
    logic [1:0]          jst;
    logic [ADC_BITS-1:0] jsa, jsb, jla, jha, jlb, jhb;
    logic [ANGLE_BITS-1:0] ang;
    logic [NORM_W-1:0]   na, nb;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pmin_a <= '0; r_pmax_a <= '1; r_pmin_b <= '0; r_pmax_b <= '1;
            r_use_preset <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MIN_A:  r_pmin_a <= cfg_data[ADC_BITS-1:0];
                REG_MAX_A:  r_pmax_a <= cfg_data[ADC_BITS-1:0];
                REG_MIN_B:  r_pmin_b <= cfg_data[ADC_BITS-1:0];
                REG_MAX_B:  r_pmax_b <= cfg_data[ADC_BITS-1:0];
                REG_USE_PR: r_use_preset <= cfg_data[0];
                default: ;
            endcase
        end
    end

    shad_front #(.ADC_BITS(ADC_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_action(s_axis_tuser),
        .i_sample_a(s_axis_tdata[ADC_BITS-1:0]),
        .i_sample_b(s_axis_tdata[2*ADC_BITS-1:ADC_BITS]),
        .i_pmin_a(r_pmin_a), .i_pmax_a(r_pmax_a),
        .i_pmin_b(r_pmin_b), .i_pmax_b(r_pmax_b),
        .i_use_preset(r_use_preset),
        .o_job_valid(jv), .i_job_ready(jr), .o_job_status(jst),
        .o_job_sa(jsa), .o_job_sb(jsb), .o_job_lo_a(jla), .o_job_hi_a(jha),
        .o_job_lo_b(jlb), .o_job_hi_b(jhb)
    );

    shad_back #(.ADC_BITS(ADC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(jv), .o_job_ready(jr), .i_job_status(jst),
        .i_job_sa(jsa), .i_job_sb(jsb), .i_job_lo_a(jla), .i_job_hi_a(jha),
        .i_job_lo_b(jlb), .i_job_hi_b(jhb),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_angle(ang), .o_norm_a(na), .o_norm_b(nb), .o_status(m_axis_tuser)
    );

    assign m_axis_tdata = OTW'({nb, na, ang});

endmodule

### dv/sincos_hall_angle_decoder_tb.sv
// Self-checking testbench of the sine/cosine Hall angle decoder.
`timescale 1ns / 1ps
module sincos_hall_angle_decoder_tb;
    import shad_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 80;

    // Arctangent steps in units of 2^-32 turn.
    localparam logic [31:0] TURN_STEP [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct {
        logic [15:0]        angle;
        logic signed [15:0] norm_a;
        logic signed [15:0] norm_b;
        logic [1:0]         status;
    } t_angle_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = ACT_RESTART;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_MIN_A;
    logic [15:0] cfg_data = '0;

    // Model state: preset registers and tracked extremes.
    int pre_min_a, pre_max_a, pre_min_b, pre_max_b, pre_use;
    int trk_min_a, trk_max_a, trk_min_b, trk_max_b;
    bit trk_valid;

    t_angle_result pending_angles[$];
    int  fail_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  cal_sent = 0;
    int  idle_cycles = 0;
    bit  tx_fast = 0;
    bit  rx_fast = 0;
    bit  hold_req = 0;
    int  rx_hold = 0;
    int  rx_wait = 0;

    sincos_hall_angle_decoder i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Linear map of a reading onto [-1,1] in Q2.14, rounded half up.
    function automatic int to_q14(int x, int lo, int hi);
        longint span, num;
        if (x <= lo) return -Q_ONE;
        if (x >= hi) return Q_ONE;
        span = hi - lo;
        num = longint'(x - lo) * 65536 + span;
        return int'(num / (2 * span)) - Q_ONE;
    endfunction

    // Vectoring rotation giving atan2(y, x) as a fraction of a turn.
    function automatic logic [31:0] turn_of(int y_in, int x_in);
        longint x, y, dx, dy;
        logic [31:0] z;
        x = longint'(x_in) * 16384;
        y = longint'(y_in) * 16384;
        z = '0;
        if (x_in == 0 && y_in == 0) return 32'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += TURN_STEP[i];
            end else begin
                x -= dx;
                y += dy;
                z -= TURN_STEP[i];
            end
        end
        return z;
    endfunction

    // Advances the model by one accepted item and queues any result.
    task automatic predict_angle(input logic [1:0] act, input int a, input int b);
        t_angle_result r;
        int lo_a, hi_a, lo_b, hi_b, na, nb;
        logic [31:0] z;
        r = '{16'd0, 16'sd0, 16'sd0, ST_OK};
        if (act == ACT_RESTART) begin
            trk_valid = 0;
        end else if (act == ACT_CAL) begin
            if (!trk_valid) begin
                trk_min_a = a; trk_max_a = a; trk_min_b = b; trk_max_b = b;
                trk_valid = 1;
            end else begin
                if (a < trk_min_a) trk_min_a = a;
                if (a > trk_max_a) trk_max_a = a;
                if (b < trk_min_b) trk_min_b = b;
                if (b > trk_max_b) trk_max_b = b;
            end
        end else if (act == ACT_MEASURE) begin
            if (pre_use != 0) begin
                lo_a = pre_min_a; hi_a = pre_max_a; lo_b = pre_min_b; hi_b = pre_max_b;
            end else begin
                lo_a = trk_min_a; hi_a = trk_max_a; lo_b = trk_min_b; hi_b = trk_max_b;
            end
            if (pre_use == 0 && !trk_valid) begin
                r.status = ST_NOCAL;
            end else if (hi_a <= lo_a || hi_b <= lo_b) begin
                r.status = ST_SPAN;
            end else begin
                na = to_q14(a, lo_a, hi_a);
                nb = to_q14(b, lo_b, hi_b);
                z = turn_of(na, nb) + 32'h80000000 + 32'h00008000;
                r.angle = z[31:16];
                r.norm_a = 16'(na);
                r.norm_b = 16'(nb);
            end
            pending_angles.push_back(r);
        end
    endtask

    // Offers one item after a random gap and waits for its transfer.
    task automatic send_item(input logic [1:0] act, input int a, input int b);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {b[11:0], a[11:0]};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_angle(act, a, b);
        items_sent++;
        if (act == ACT_CAL) cal_sent++;
    endtask

    // Stops offering and waits until every expected result has arrived.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register; only called once the block is idle.
    task automatic write_reg(input logic [2:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        if (idx == REG_USE_PR)
            cfg_data <= {15'($urandom_range(0, 32767)), val[0]};
        else
            cfg_data <= {4'($urandom_range(0, 15)), val[11:0]};
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_A: pre_min_a = val & 12'hFFF;
            REG_MAX_A: pre_max_a = val & 12'hFFF;
            REG_MIN_B: pre_min_b = val & 12'hFFF;
            REG_MAX_B: pre_max_b = val & 12'hFFF;
            default:   pre_use = val & 1;
        endcase
    endtask

    task automatic write_all(input int mn_a, input int mx_a, input int mn_b, input int mx_b,
                             input int use_pr);
        drain_results();
        write_reg(REG_MIN_A, mn_a);
        write_reg(REG_MAX_A, mx_a);
        write_reg(REG_MIN_B, mn_b);
        write_reg(REG_MAX_B, mx_b);
        write_reg(REG_USE_PR, use_pr);
    endtask

    // Reading biased towards the ends of the ADC range.
    function automatic int rand_reading();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 4095;
            2: return $urandom_range(0, 40);
            3: return $urandom_range(4055, 4095);
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    // Extremes, zero vectors, ignored codes and both error statuses.
    task automatic test_directed();
        send_item(ACT_MEASURE, 0, 0);
        send_item(ACT_MEASURE, 4095, 4095);
        send_item(ACT_MEASURE, 4095, 0);
        send_item(ACT_MEASURE, 0, 4095);
        send_item(ACT_MEASURE, 2048, 2047);
        send_item(2'd3, 1234, 3210);
        write_all(0, 4094, 0, 4094, 1);
        send_item(ACT_MEASURE, 2047, 2047);
        send_item(ACT_MEASURE, 2047, 4000);
        send_item(ACT_MEASURE, 100, 2047);
        write_all(4095, 0, 0, 4095, 0);
        send_item(ACT_MEASURE, 100, 200);
        send_item(ACT_CAL, 1000, 3000);
        send_item(ACT_MEASURE, 1000, 3000);
        send_item(ACT_CAL, 3000, 1000);
        send_item(ACT_MEASURE, 2000, 2000);
        send_item(ACT_MEASURE, 4095, 0);
        send_item(ACT_RESTART, 0, 0);
        send_item(ACT_MEASURE, 2000, 2000);
        send_item(ACT_CAL, 2500, 2500);
        send_item(ACT_MEASURE, 2500, 2500);
        write_all(4095, 0, 0, 4095, 1);
        send_item(ACT_MEASURE, 500, 500);
        write_all(0, 4095, 4095, 4095, 1);
        send_item(ACT_MEASURE, 500, 500);
    endtask

    // Calibrate then measure with tracked extremes, with some noise mixed in.
    task automatic test_tracking_random(input int n_items);
        int stop_at, k;
        stop_at = items_sent + n_items;
        write_all(rand_reading(), rand_reading(), rand_reading(), rand_reading(), 0);
        while (items_sent < stop_at) begin
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) != 0) send_item(ACT_RESTART, rand_reading(), rand_reading());
            k = $urandom_range(1, 8);
            repeat (k) send_item(ACT_CAL, rand_reading(), rand_reading());
            k = $urandom_range(1, 10);
            repeat (k) begin
                case ($urandom_range(0, 11))
                    0: send_item(2'd3, rand_reading(), rand_reading());
                    1: send_item(ACT_CAL, rand_reading(), rand_reading());
                    2: send_item(ACT_RESTART, rand_reading(), rand_reading());
                    default: send_item(ACT_MEASURE, rand_reading(), rand_reading());
                endcase
            end
        end
    endtask

    // Preset extremes, mostly well ordered, with occasional bad spans.
    task automatic test_preset_random(input int n_items);
        int stop_at, lo_a, hi_a, lo_b, hi_b, span_a, span_b;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            lo_a = $urandom_range(0, 2000);
            lo_b = $urandom_range(0, 2000);
            span_a = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 2095);
            span_b = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 2095);
            hi_a = lo_a + span_a;
            hi_b = lo_b + span_b;
            if ($urandom_range(0, 7) == 0) hi_a = $urandom_range(0, lo_a);
            if ($urandom_range(0, 7) == 0) hi_b = $urandom_range(0, lo_b);
            if ($urandom_range(0, 5) == 0) begin
                lo_a = 0; hi_a = 4095;
            end
            write_all(lo_a, hi_a, lo_b, hi_b, 1);
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(20, 60)) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(2'($urandom_range(0, 3)), rand_reading(), rand_reading());
                else
                    send_item(ACT_MEASURE, rand_reading(), rand_reading());
            end
        end
    endtask

    // Long receiver hold while measures keep coming, so the queue fills up.
    task automatic test_backpressure();
        write_all(0, 4095, 0, 4095, 1);
        tx_fast = 1;
        hold_req <= 1'b1;
        repeat (20) send_item(ACT_MEASURE, rand_reading(), rand_reading());
        tx_fast = 0;
        drain_results();
    endtask

    // Receiver: random stalls per result, or a long hold on request.
    always @(posedge i_clk) begin
        int w;
        if (hold_req) begin
            hold_req <= 1'b0;
            rx_hold <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            if (rx_hold == 1) m_axis_tready <= 1'b1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (!rx_fast) begin
                w = $urandom_range(0, 17);
                rx_wait <= w;
                if (w > 0) m_axis_tready <= 1'b0;
            end
        end else if (!m_axis_tready) begin
            if (rx_wait <= 1) m_axis_tready <= 1'b1;
            rx_wait <= rx_wait - 1;
        end
    end

    // Compares each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_angle_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_angles.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%0d", $time,
                         m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                e = pending_angles.pop_front();
                if (m_axis_tdata[15:0] !== e.angle || m_axis_tdata[31:16] !== e.norm_a
                        || m_axis_tdata[47:32] !== e.norm_b || m_axis_tuser !== e.status) begin
                    $display("%0t: expected angle=%0d a=%0d b=%0d st=%0d, got angle=%0d a=%0d b=%0d st=%0d",
                             $time, e.angle, e.norm_a, e.norm_b, e.status,
                             m_axis_tdata[15:0], $signed(m_axis_tdata[31:16]),
                             $signed(m_axis_tdata[47:32]), m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog over cycles with no transfer on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sincos_hall_angle_decoder: mismatch");
            $finish;
        end
    end

    initial begin
        pre_min_a = 0; pre_max_a = 4095; pre_min_b = 0; pre_max_b = 4095; pre_use = 1;
        trk_min_a = 0; trk_max_a = 0; trk_min_b = 0; trk_max_b = 0; trk_valid = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_tracking_random(900);
        test_preset_random(850);
        drain_results();
        if (pending_angles.size() != 0) fail_count++;
        $display("Sent %0d items (%0d calibration samples) over tracked and preset extremes,",
                 items_sent, cal_sent);
        $display("checked %0d results including a long output hold.", results_seen);
        if (fail_count == 0) begin
            $display("sincos_hall_angle_decoder: match");
        end else begin
            $display("sincos_hall_angle_decoder: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
sv/shad_pkg.sv
sv/shad_front.sv
sv/shad_back.sv
sv/sincos_hall_angle_decoder.sv
dv/sincos_hall_angle_decoder_tb.sv
